// File: sv/sql_row_returning_classifier_core_macros.svh
// Assertion macros shared by the row-returning classifier RTL
`ifndef SQL_ROW_RETURNING_CLASSIFIER_CORE_MACROS_SVH
`define SQL_ROW_RETURNING_CLASSIFIER_CORE_MACROS_SVH

// check cons in the same cycle as ante
`define SQLRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define SQLRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sqlrc_pkg.sv
// Package: types, codes, character classes and keyword constants of the classifier
package sqlrc_pkg;

    typedef struct packed {
        logic [7:0] sql_byte;
        logic       last;
    } sqlrc_in_t;

    typedef struct packed {
        logic       returns_rows;
        logic [2:0] lead_keyword;
        logic       returning_seen;
    } sqlrc_out_t;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_QUOTE  = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;
    localparam logic [1:0] MODE_BLOCK  = 2'd3;

    localparam logic [1:0] OPEN_NONE  = 2'd0;
    localparam logic [1:0] OPEN_DASH  = 2'd1;
    localparam logic [1:0] OPEN_SLASH = 2'd2;

    localparam logic [1:0] LEAD_SKIP    = 2'd0;
    localparam logic [1:0] LEAD_COLLECT = 2'd1;
    localparam logic [1:0] LEAD_DONE    = 2'd2;

    localparam logic [2:0] KW_NONE    = 3'd0;
    localparam logic [2:0] KW_SELECT  = 3'd1;
    localparam logic [2:0] KW_WITH    = 3'd2;
    localparam logic [2:0] KW_PRAGMA  = 3'd3;
    localparam logic [2:0] KW_EXPLAIN = 3'd4;

    localparam int LEAD_MAX = 7;
    localparam logic [3:0] WORD_LEN = 4'd9;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_LF     = 8'h0a;

    // lower-case keyword text, first letter in the low byte
    localparam logic [8*LEAD_MAX-1:0] TEXT_SELECT  = 56'h007463656c6573;
    localparam logic [8*LEAD_MAX-1:0] TEXT_WITH    = 56'h00000068746977;
    localparam logic [8*LEAD_MAX-1:0] TEXT_PRAGMA  = 56'h00616d67617270;
    localparam logic [8*LEAD_MAX-1:0] TEXT_EXPLAIN = 56'h6e69616c707865;
    localparam logic [2:0] LEN_SELECT  = 3'd6;
    localparam logic [2:0] LEN_WITH    = 3'd4;
    localparam logic [2:0] LEN_PRAGMA  = 3'd6;
    localparam logic [2:0] LEN_EXPLAIN = 3'd7;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == 8'h5f;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
    endfunction

    // letters of "returning" by position
    function automatic logic [7:0] returning_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h72;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h75;
            4'd4:    c = 8'h72;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h69;
            4'd7:    c = 8'h6e;
            4'd8:    c = 8'h67;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: sv/sqlrc_scan.sv
// Byte scanner: running lexical state and the result for the final byte
module sqlrc_scan
    import sqlrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  sqlrc_in_t  byte_in,
    output sqlrc_out_t result
);

    logic [1:0]              scan_mode_reg, scan_mode_next;
    logic                    quote_kind_reg, quote_kind_next;
    logic                    close_pending_reg, close_pending_next;
    logic [1:0]              opener_reg, opener_next;
    logic                    star_seen_reg, star_seen_next;
    logic                    after_word_reg, after_word_next;
    logic [3:0]              match_count_reg, match_count_next;
    logic                    found_reg, found_next;
    logic [1:0]              lead_phase_reg, lead_phase_next;
    logic [8*LEAD_MAX-1:0]   lead_text_reg, lead_text_next;
    logic [2:0]              lead_length_reg, lead_length_next;

    logic [7:0] b;
    logic [7:0] fb;
    logic [7:0] q;
    logic       do_plain;
    logic       found_final;
    logic [2:0] kw;

    assign b  = byte_in.sql_byte;
    assign fb = fold(b);
    assign q  = quote_kind_reg ? CH_DQUOTE : CH_SQUOTE;

    always_comb
    begin
        scan_mode_next     = scan_mode_reg;
        quote_kind_next    = quote_kind_reg;
        close_pending_next = close_pending_reg;
        opener_next        = opener_reg;
        star_seen_next     = star_seen_reg;
        match_count_next   = match_count_reg;
        found_next         = found_reg;
        lead_phase_next    = lead_phase_reg;
        lead_text_next     = lead_text_reg;
        lead_length_next   = lead_length_reg;
        do_plain           = 1'b0;

        // settle a full word match on the byte after it
        if (match_count_reg >= WORD_LEN)
        begin
            if (!is_word(b))
                found_next = 1'b1;
            match_count_next = 4'd0;
        end

        unique case (scan_mode_reg)
            MODE_QUOTE:
            begin
                if (close_pending_reg)
                begin
                    close_pending_next = 1'b0;
                    if (b != q)
                    begin
                        scan_mode_next = MODE_NORMAL;
                        do_plain       = 1'b1;
                    end
                end
                else if (b == q)
                begin
                    close_pending_next = 1'b1;
                end
            end
            MODE_LINE:
            begin
                if (b == CH_LF)
                begin
                    scan_mode_next = MODE_NORMAL;
                    do_plain       = 1'b1;
                end
            end
            MODE_BLOCK:
            begin
                if (star_seen_reg && b == CH_SLASH)
                begin
                    scan_mode_next = MODE_NORMAL;
                    star_seen_next = 1'b0;
                end
                else
                begin
                    star_seen_next = (b == CH_STAR);
                end
            end
            MODE_NORMAL:
            begin
                opener_next = OPEN_NONE;
                if (opener_reg == OPEN_DASH && b == CH_DASH)
                begin
                    scan_mode_next = MODE_LINE;
                end
                else if (opener_reg == OPEN_SLASH && b == CH_STAR)
                begin
                    scan_mode_next = MODE_BLOCK;
                    star_seen_next = 1'b0;
                end
                else
                begin
                    do_plain = 1'b1;
                end
            end
        endcase

        if (do_plain)
        begin
            if (b == CH_SQUOTE || b == CH_DQUOTE)
            begin
                scan_mode_next     = MODE_QUOTE;
                quote_kind_next    = (b == CH_DQUOTE);
                close_pending_next = 1'b0;
                match_count_next   = 4'd0;
            end
            else if (b == CH_DASH || b == CH_SLASH)
            begin
                opener_next      = (b == CH_DASH) ? OPEN_DASH : OPEN_SLASH;
                match_count_next = 4'd0;
            end
            else if (!after_word_reg && fb == returning_char(4'd0))
            begin
                match_count_next = 4'd1;
            end
            else if (match_count_next > 4'd0 && match_count_next < WORD_LEN &&
                     fb == returning_char(match_count_next))
            begin
                match_count_next = match_count_next + 4'd1;
            end
            else
            begin
                match_count_next = 4'd0;
            end
        end

        // leading word: skip whitespace, collect up to seven letters
        if (lead_phase_reg == LEAD_SKIP && !is_space(b))
            lead_phase_next = LEAD_COLLECT;
        if (lead_phase_next == LEAD_COLLECT)
        begin
            if (is_alpha(b) && lead_length_reg < 3'(LEAD_MAX))
            begin
                for (int i = 0; i < LEAD_MAX; i++)
                begin
                    if (lead_length_reg == 3'(i))
                        lead_text_next[8*i +: 8] = fb;
                end
                lead_length_next = lead_length_reg + 3'd1;
            end
            else
            begin
                lead_phase_next = LEAD_DONE;
            end
        end
    end

    assign after_word_next = is_word(b);
    assign found_final     = found_next || (match_count_next >= WORD_LEN);

    always_comb
    begin
        if (lead_length_next == LEN_SELECT && lead_text_next == TEXT_SELECT)
            kw = KW_SELECT;
        else if (lead_length_next == LEN_WITH && lead_text_next == TEXT_WITH)
            kw = KW_WITH;
        else if (lead_length_next == LEN_PRAGMA && lead_text_next == TEXT_PRAGMA)
            kw = KW_PRAGMA;
        else if (lead_length_next == LEN_EXPLAIN && lead_text_next == TEXT_EXPLAIN)
            kw = KW_EXPLAIN;
        else
            kw = KW_NONE;
    end

    assign result.returns_rows   = (kw != KW_NONE) || found_final;
    assign result.lead_keyword   = kw;
    assign result.returning_seen = found_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg     <= MODE_NORMAL;
            quote_kind_reg    <= 1'b0;
            close_pending_reg <= 1'b0;
            opener_reg        <= OPEN_NONE;
            star_seen_reg     <= 1'b0;
            after_word_reg    <= 1'b0;
            match_count_reg   <= 4'd0;
            found_reg         <= 1'b0;
            lead_phase_reg    <= LEAD_SKIP;
            lead_text_reg     <= '0;
            lead_length_reg   <= 3'd0;
        end
        else if (take)
        begin
            if (byte_in.last)
            begin
                // restart for the next statement
                scan_mode_reg     <= MODE_NORMAL;
                quote_kind_reg    <= 1'b0;
                close_pending_reg <= 1'b0;
                opener_reg        <= OPEN_NONE;
                star_seen_reg     <= 1'b0;
                after_word_reg    <= 1'b0;
                match_count_reg   <= 4'd0;
                found_reg         <= 1'b0;
                lead_phase_reg    <= LEAD_SKIP;
                lead_text_reg     <= '0;
                lead_length_reg   <= 3'd0;
            end
            else
            begin
                scan_mode_reg     <= scan_mode_next;
                quote_kind_reg    <= quote_kind_next;
                close_pending_reg <= close_pending_next;
                opener_reg        <= opener_next;
                star_seen_reg     <= star_seen_next;
                after_word_reg    <= after_word_next;
                match_count_reg   <= match_count_next;
                found_reg         <= found_next;
                lead_phase_reg    <= lead_phase_next;
                lead_text_reg     <= lead_text_next;
                lead_length_reg   <= lead_length_next;
            end
        end
    end

endmodule

// File: sv/sql_row_returning_classifier_core.sv
// Top level: row-returning classifier, one byte per cycle while byte_ready is high, registered result with skid stage
// The result for the last byte is registered in the output stage, or in the skid stage on a stall.
// Throughput: one byte per cycle while byte_ready is high, set by the scanner state update.
// byte_ready falls only while the skid stage holds a second result behind a stalled output.
// Reset (rst_n low) clears the scanner state and empties the output and skid stages.
`include "sql_row_returning_classifier_core_macros.svh"
module sql_row_returning_classifier_core
    import sqlrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  sqlrc_in_t  byte_data,
    output logic       result_valid,
    input  logic       result_ready,
    output sqlrc_out_t result_data
);

    logic       take;
    logic       produce;
    logic       out_free;
    logic       stall_produce;
    logic       rows_ok;
    sqlrc_out_t scan_result;

    logic       out_valid_reg;
    sqlrc_out_t out_data_reg;
    logic       skid_valid_reg;
    sqlrc_out_t skid_data_reg;

    assign byte_ready = !skid_valid_reg;
    assign take       = byte_valid && byte_ready;
    assign produce    = take && byte_data.last;
    assign out_free   = !out_valid_reg || result_ready;

    sqlrc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (byte_data),
        .result  (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (produce)
                out_data_reg <= scan_result;
        end
        else if (produce)
        begin
            skid_data_reg <= scan_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign stall_produce = produce && out_valid_reg && !result_ready;
    assign rows_ok       = result_data.returns_rows ==
                           (result_data.lead_keyword != KW_NONE || result_data.returning_seen);

    `SQLRC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output")
    `SQLRC_ASSERT_NEXT(a_stall_to_skid, stall_produce, skid_valid_reg, "result lost on stall")
    `SQLRC_ASSERT_SAME(a_rows_consistent, result_valid, rows_ok, "returns_rows inconsistent")

endmodule
